// File: sv/bif_pkg.sv
// Shared types, constants and a helper function for the bilateral image filter.
// Depends on nothing; every other file in this folder imports it.
package bif_pkg;

    // frame store geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_RADIUS = 7;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int POS_W      = X_W + Y_W;
    localparam int NPIX_W     = POS_W + 1;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // register and field widths
    localparam int DIM_W     = 7;
    localparam int R_W       = 3;
    localparam int COEF_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W  = 16;

    // arithmetic widths
    localparam int COORD_W  = DIM_W + 1;
    localparam int DXW      = R_W + 1;
    localparam int D2_W     = 2 * R_W + 1;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SP_W     = COEF_W + D2_W;
    localparam int E_W      = SQ_W + 1;
    localparam int W_W      = SAMPLE_W + 1;
    localparam int PROD_W   = W_W + SAMPLE_W;
    localparam int TAPS_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int DEN_W    = $clog2(TAPS_MAX + 1) + W_W;
    localparam int NUM_W    = DEN_W + SAMPLE_W;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_WINDOW_RADIUS = 3'd2,
        CFG_SPATIAL_COEFF = 3'd3,
        CFG_RANGE_COEFF   = 3'd4,
        CFG_USE_GUIDE     = 3'd5,
        CFG_BORDER_MODE   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] guide_sample;
    } bif_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                last;
    } bif_out_t;

    // configuration as the datapath sees it, sizes already clamped
    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [R_W-1:0]    window_radius;
        logic [COEF_W-1:0] spatial_coeff;
        logic [COEF_W-1:0] range_coeff;
        logic              use_guide;
        logic              border_mode;
        logic [NPIX_W-1:0] npix;
    } bif_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic open_item;
        logic setup_step;
        logic centre_rd;
        logic tap_issue;
        logic div_start;
    } bif_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic setup_last;
        logic tap_last;
        logic pipe_busy;
        logic div_done;
    } bif_stat_t;

    // 2^-e with e in Q.16: linear fraction then shift
    function automatic logic [W_W-1:0] tap_weight(input logic [E_W-1:0] e);
        logic [E_W-17:0] n;
        logic [14:0]     fh;
        logic [W_W-1:0]  base;
        n    = e[E_W-1:16];
        fh   = e[15:1];
        base = W_W'(65536) - {2'b00, fh};
        if (n >= (E_W-16)'(W_W))
            return '0;
        else
            return base >> n[4:0];
    endfunction

endpackage

// File: sv/bif_cfg.sv
// Configuration register file for the bilateral image filter.
// Depends on bif_pkg; clamps frame size and radius for the datapath.
module bif_cfg
    import bif_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output bif_cfg_t             cfg
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [R_W-1:0]    radius_reg;
    logic [COEF_W-1:0] spatial_reg;
    logic [COEF_W-1:0] range_reg;
    logic              guide_reg;
    logic              border_reg;
    logic [DIM_W-1:0]  w_clamp;
    logic [DIM_W-1:0]  h_clamp;
    logic [2*DIM_W-1:0] npix_full;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_W'(64);
            height_reg  <= DIM_W'(64);
            radius_reg  <= R_W'(3);
            spatial_reg <= COEF_W'(5243);
            range_reg   <= COEF_W'(461568);
            guide_reg   <= 1'b0;
            border_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:   width_reg   <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  height_reg  <= cfg_data[DIM_W-1:0];
                CFG_WINDOW_RADIUS: radius_reg  <= cfg_data[R_W-1:0];
                CFG_SPATIAL_COEFF: spatial_reg <= cfg_data[COEF_W-1:0];
                CFG_RANGE_COEFF:   range_reg   <= cfg_data[COEF_W-1:0];
                CFG_USE_GUIDE:     guide_reg   <= cfg_data[0];
                CFG_BORDER_MODE:   border_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // clamp sizes into the store
    always_comb
    begin
        if (width_reg == '0)
            w_clamp = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_clamp = DIM_W'(MAX_WIDTH);
        else
            w_clamp = width_reg;
        if (height_reg == '0)
            h_clamp = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_clamp = DIM_W'(MAX_HEIGHT);
        else
            h_clamp = height_reg;
        npix_full = w_clamp * h_clamp;
    end

    always_comb
    begin
        cfg.frame_width   = w_clamp;
        cfg.frame_height  = h_clamp;
        cfg.window_radius = (radius_reg > R_W'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : radius_reg;
        cfg.spatial_coeff = spatial_reg;
        cfg.range_coeff   = range_reg;
        cfg.use_guide     = guide_reg;
        cfg.border_mode   = border_reg;
        cfg.npix          = npix_full[NPIX_W-1:0];
    end

endmodule

// File: sv/bif_divider.sv
// Restoring divider, one quotient bit per cycle, for the weighted mean.
// Depends on bif_pkg; the quotient is known to fit in one sample.
module bif_divider
    import bif_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output logic                done,
    output logic [SAMPLE_W-1:0] quot
);

    localparam int CNT_W = $clog2(SAMPLE_W);

    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                run_reg;
    logic                done_reg;
    logic [DEN_W:0]      trial;
    logic                ge;

    // one trial subtraction
    always_comb
    begin
        trial    = {rem_reg, lo_reg[SAMPLE_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        lo_next  = {lo_reg[SAMPLE_W-2:0], ge};
    end

    // operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:SAMPLE_W];
            lo_reg  <= num[SAMPLE_W-1:0];
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SAMPLE_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

// File: sv/bif_datapath.sv
// Datapath: frame store, position logic, window walk, weight pipeline,
// accumulators and divider. Depends on bif_pkg, bif_divider.
module bif_datapath
    import bif_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bif_cfg_t  cfg,
    input  bif_in_t   req,
    input  bif_cmd_t  cmd,
    output bif_stat_t stat,
    output bif_out_t  result
);

    // frame store
    logic [SAMPLE_W-1:0] value_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] guide_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] vrd_reg;
    logic [SAMPLE_W-1:0] grd_reg;
    logic [POS_W-1:0]    rd_addr;

    // positions
    logic [POS_W-1:0] lp_reg, lp_eff;
    logic [POS_W-1:0] op_reg, op_eff;
    logic [POS_W-1:0] pos_reg;
    logic             last_reg;
    logic [NPIX_W-1:0] lp_inc, op_inc;

    // centre coordinates from pos / width
    logic [X_W-1:0]   xr_reg;
    logic [Y_W-1:0]   yq_reg;
    logic [DIM_W-1:0] xtrial;
    logic             xge;
    logic [2:0]       scnt_reg;

    // window walk
    logic signed [DXW-1:0]     dx_reg, dy_reg;
    logic signed [DXW-1:0]     r_s;
    logic signed [COORD_W-1:0] tx, ty, txc, tyc, w_s, h_s;
    logic                      outside;
    logic                      tap_ok;
    logic [R_W-1:0]            adx, ady;
    logic [2*R_W-1:0]          sqx, sqy;
    logic [D2_W-1:0]           d2;
    logic [Y_W+DIM_W-1:0]      rowbase;
    logic [POS_W-1:0]          tap_addr;

    // pipeline stages
    logic                centre_pend_reg;
    logic [SAMPLE_W-1:0] centre_reg;
    logic                vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic [D2_W-1:0]     d2b_reg;
    logic [SQ_W-1:0]     sqc_reg;
    logic [SP_W-1:0]     spc_reg, spd_reg;
    logic [SAMPLE_W-1:0] valc_reg, vald_reg, vale_reg;
    logic [SQ_W-1:0]     rngd_reg;
    logic [W_W-1:0]      wte_reg, wtf_reg;
    logic [PROD_W-1:0]   prodf_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [SAMPLE_W-1:0] rv, diff;
    logic [SQ_W-1:0]     sq;
    logic [SP_W-1:0]     sp;
    logic [COEF_W+SQ_W-1:0] rprod;
    logic [E_W-1:0]      e;
    logic [PROD_W-1:0]   prod;
    logic                div_done;
    logic [SAMPLE_W-1:0] quot;

    // wrapped positions
    always_comb
    begin
        lp_eff = ({1'b0, lp_reg} >= cfg.npix) ? '0 : lp_reg;
        op_eff = ({1'b0, op_reg} >= cfg.npix) ? '0 : op_reg;
        lp_inc = {1'b0, lp_eff} + 1'b1;
        op_inc = {1'b0, op_eff} + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= '0;
            op_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                lp_reg <= (lp_inc >= cfg.npix) ? '0 : lp_inc[POS_W-1:0];
            if (cmd.open_item)
                op_reg <= (op_inc >= cfg.npix) ? '0 : op_inc[POS_W-1:0];
        end
    end

    // store write and registered read
    assign rd_addr = cmd.centre_rd ? pos_reg : tap_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_mem[lp_eff] <= req.sample;
            guide_mem[lp_eff] <= req.guide_sample;
        end
        vrd_reg <= value_mem[rd_addr];
        grd_reg <= guide_mem[rd_addr];
    end

    // row and column of the centre, one quotient bit a cycle
    assign xtrial = {xr_reg, yq_reg[Y_W-1]};
    assign xge    = (xtrial >= cfg.frame_width);

    always_ff @(posedge clk)
    begin
        if (cmd.open_item)
        begin
            pos_reg  <= op_eff;
            last_reg <= (op_inc == cfg.npix);
            xr_reg   <= op_eff[POS_W-1:Y_W];
            yq_reg   <= op_eff[Y_W-1:0];
        end
        else if (cmd.setup_step)
        begin
            xr_reg <= xge ? X_W'(xtrial - cfg.frame_width) : xtrial[X_W-1:0];
            yq_reg <= {yq_reg[Y_W-2:0], xge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scnt_reg <= '0;
        else if (cmd.open_item)
            scnt_reg <= '0;
        else if (cmd.setup_step)
            scnt_reg <= scnt_reg + 1'b1;
    end

    // tap coordinates, border handling and address
    always_comb
    begin
        r_s = $signed({1'b0, cfg.window_radius});
        w_s = $signed({1'b0, cfg.frame_width});
        h_s = $signed({1'b0, cfg.frame_height});
        tx  = $signed({{(COORD_W-X_W){1'b0}}, xr_reg})
            + {{(COORD_W-DXW){dx_reg[DXW-1]}}, dx_reg};
        ty  = $signed({{(COORD_W-Y_W){1'b0}}, yq_reg})
            + {{(COORD_W-DXW){dy_reg[DXW-1]}}, dy_reg};
        outside = (tx < 0) || (tx >= w_s) || (ty < 0) || (ty >= h_s);
        tap_ok  = !outside || cfg.border_mode;
        if (tx < 0)
            txc = '0;
        else if (tx >= w_s)
            txc = w_s - $signed(COORD_W'(1));
        else
            txc = tx;
        if (ty < 0)
            tyc = '0;
        else if (ty >= h_s)
            tyc = h_s - $signed(COORD_W'(1));
        else
            tyc = ty;
        rowbase  = tyc[Y_W-1:0] * cfg.frame_width;
        tap_addr = rowbase[POS_W-1:0] + {{(POS_W-X_W){1'b0}}, txc[X_W-1:0]};
        adx = dx_reg[DXW-1] ? R_W'(-dx_reg) : dx_reg[R_W-1:0];
        ady = dy_reg[DXW-1] ? R_W'(-dy_reg) : dy_reg[R_W-1:0];
        sqx = adx * adx;
        sqy = ady * ady;
        d2  = {1'b0, sqx} + {1'b0, sqy};
    end

    // window scan, row by row
    always_ff @(posedge clk)
    begin
        if (cmd.open_item)
        begin
            dx_reg <= -r_s;
            dy_reg <= -r_s;
        end
        else if (cmd.tap_issue)
        begin
            if (dx_reg == r_s)
            begin
                dx_reg <= -r_s;
                dy_reg <= dy_reg + $signed(DXW'(1));
            end
            else
                dx_reg <= dx_reg + $signed(DXW'(1));
        end
    end

    // centre sample of the range plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            centre_pend_reg <= 1'b0;
        else
            centre_pend_reg <= cmd.centre_rd;
    end

    always_ff @(posedge clk)
    begin
        if (centre_pend_reg)
            centre_reg <= cfg.use_guide ? grd_reg : vrd_reg;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= cmd.tap_issue && tap_ok;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    // weight arithmetic
    always_comb
    begin
        rv    = cfg.use_guide ? grd_reg : vrd_reg;
        diff  = (rv > centre_reg) ? (rv - centre_reg) : (centre_reg - rv);
        sq    = diff * diff;
        sp    = cfg.spatial_coeff * d2b_reg;
        rprod = cfg.range_coeff * sqc_reg;
        e     = {1'b0, spd_reg} + {1'b0, rngd_reg};
        prod  = wte_reg * vale_reg;
    end

    always_ff @(posedge clk)
    begin
        d2b_reg   <= d2;
        sqc_reg   <= sq;
        spc_reg   <= sp;
        valc_reg  <= vrd_reg;
        rngd_reg  <= rprod[COEF_W+SQ_W-1:COEF_W];
        spd_reg   <= spc_reg;
        vald_reg  <= valc_reg;
        wte_reg   <= tap_weight(e);
        vale_reg  <= vald_reg;
        prodf_reg <= prod;
        wtf_reg   <= wte_reg;
    end

    // weighted sums
    always_ff @(posedge clk)
    begin
        if (cmd.open_item)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (vf_reg)
        begin
            num_reg <= num_reg + {{(NUM_W-PROD_W){1'b0}}, prodf_reg};
            den_reg <= den_reg + {{(DEN_W-W_W){1'b0}}, wtf_reg};
        end
    end

    bif_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        stat.setup_last = (scnt_reg == 3'(Y_W - 1));
        stat.tap_last   = (dx_reg == r_s) && (dy_reg == r_s);
        stat.pipe_busy  = vb_reg || vc_reg || vd_reg || ve_reg || vf_reg;
        stat.div_done   = div_done;
        result.filtered = quot;
        result.last     = last_reg;
    end

endmodule

// File: sv/bif_ctrl.sv
// Controller state machine sequencing loads and filter computations.
// Depends on bif_pkg; drives the datapath through command and status structs.
module bif_ctrl
    import bif_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      command,
    input  bif_stat_t stat,
    output bif_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SETUP  = 7'b0000010,
        S_CENTRE = 7'b0000100,
        S_TAPS   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && command == CMD_COMPUTE)
                begin
                    cmd.open_item = 1'b1;
                    state_next    = S_SETUP;
                end
                else if (start)
                    cmd.load = 1'b1;
            end
            S_SETUP:
            begin
                cmd.setup_step = 1'b1;
                if (stat.setup_last)
                    state_next = S_CENTRE;
            end
            S_CENTRE:
            begin
                cmd.centre_rd = 1'b1;
                state_next    = S_TAPS;
            end
            S_TAPS:
            begin
                cmd.tap_issue = 1'b1;
                if (stat.tap_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

`ifndef SYNTHESIS
    // a compute transaction makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_COMPUTE) |=> busy)
        else $error("compute transaction not taken");
    // a load transaction never raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOAD) |=> !busy)
        else $error("load transaction raised busy");
    // every result strobe closes the item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("result strobe longer than one cycle");
    // divider only started with the window fully accumulated
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.pipe_busy && !cmd.tap_issue)
        else $error("divider started with taps in flight");
`endif

endmodule

// File: sv/bilateral_image_filter.sv
// Bilateral image filter, top level: config registers, controller, datapath.
// Depends on bif_pkg, bif_cfg, bif_ctrl, bif_datapath, bif_divider.
//
// A load transaction (command 0) writes the next pixel of the frame store
// and leaves busy low. A compute transaction (command 1) keeps busy high
// while it splits the position into row and column, reads the centre
// sample, issues each window tap through the single read port of the frame
// store, drains the weight pipeline (sooner when trailing border taps are
// dropped), runs the bit-serial divider for the weighted mean and shows the
// result. The result is shown for exactly one cycle with done high and
// cannot be stalled.
module bilateral_image_filter
    import bif_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bif_in_t              req,
    output logic                 done,
    output bif_out_t             result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    bif_cfg_t  cfg;
    bif_cmd_t  cmd;
    bif_stat_t stat;

    bif_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bif_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (req.command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    bif_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// File: test/tb_bilateral_image_filter.sv
// Testbench for the bilateral image filter: loads frames, issues computes and
// checks every filtered pixel against an in-bench predictor.
// Depends on bif_pkg and the bilateral_image_filter top level.
`timescale 1ns / 100ps

import bif_pkg::*;

// expected pixel store and the filter arithmetic that fills it
class pixel_scoreboard;
    logic [SAMPLE_W-1:0] value_plane [STORE_DEPTH];
    logic [SAMPLE_W-1:0] guide_plane [STORE_DEPTH];
    int unsigned         load_pos;
    int unsigned         out_pos;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [R_W-1:0]      radius_reg;
    logic [COEF_W-1:0]   spatial_reg;
    logic [COEF_W-1:0]   range_reg;
    logic                guide_reg;
    logic                border_reg;
    bif_out_t            pending[$];
    int                  errors;

    function new();
        load_pos    = 0;
        out_pos     = 0;
        width_reg   = 64;
        height_reg  = 64;
        radius_reg  = 3;
        spatial_reg = 5243;
        range_reg   = 461568;
        guide_reg   = 0;
        border_reg  = 0;
        errors      = 0;
        foreach (value_plane[i])
        begin
            value_plane[i] = '0;
            guide_plane[i] = '0;
        end
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH:   width_reg   = data[DIM_W-1:0];
            CFG_FRAME_HEIGHT:  height_reg  = data[DIM_W-1:0];
            CFG_WINDOW_RADIUS: radius_reg  = data[R_W-1:0];
            CFG_SPATIAL_COEFF: spatial_reg = data[COEF_W-1:0];
            CFG_RANGE_COEFF:   range_reg   = data[COEF_W-1:0];
            CFG_USE_GUIDE:     guide_reg   = data[0];
            CFG_BORDER_MODE:   border_reg  = data[0];
            default: ;
        endcase
    endfunction

    function int frame_w();
        return (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function int frame_h();
        return (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
            : int'(height_reg);
    endfunction

    // 2^-e, linear on the fraction
    function longint unsigned exp2_weight(longint unsigned e);
        longint unsigned n;
        longint unsigned f;
        n = e >> 16;
        f = e & 64'hFFFF;
        if (n >= 17)
            return 0;
        return (65536 - (f >> 1)) >> n;
    endfunction

    function void note_input(bif_in_t item);
        int              w;
        int              h;
        int              r;
        int unsigned     npix;
        int unsigned     pos;
        int              x;
        int              y;
        int              tx;
        int              ty;
        int unsigned     idx;
        longint unsigned centre;
        longint unsigned rv;
        longint unsigned diff;
        longint unsigned e;
        longint unsigned wt;
        longint unsigned num;
        longint unsigned den;
        bif_out_t        res;
        w    = frame_w();
        h    = frame_h();
        r    = int'(radius_reg);
        npix = w * h;
        if (item.command == CMD_LOAD)
        begin
            if (load_pos >= npix)
                load_pos = 0;
            value_plane[load_pos] = item.sample;
            guide_plane[load_pos] = item.guide_sample;
            load_pos = (load_pos + 1 >= npix) ? 0 : load_pos + 1;
            return;
        end
        if (out_pos >= npix)
            out_pos = 0;
        pos    = out_pos;
        x      = pos % w;
        y      = pos / w;
        centre = guide_reg ? guide_plane[pos] : value_plane[pos];
        num    = 0;
        den    = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            for (int dx = -r; dx <= r; dx++)
            begin
                ty = y + dy;
                tx = x + dx;
                if (ty < 0 || ty >= h || tx < 0 || tx >= w)
                begin
                    if (!border_reg)
                        continue;
                    ty = (ty < 0) ? 0 : (ty >= h) ? h - 1 : ty;
                    tx = (tx < 0) ? 0 : (tx >= w) ? w - 1 : tx;
                end
                idx  = ty * w + tx;
                rv   = guide_reg ? guide_plane[idx] : value_plane[idx];
                diff = (rv > centre) ? rv - centre : centre - rv;
                e    = longint'(spatial_reg) * longint'(dx * dx + dy * dy)
                     + ((longint'(range_reg) * (diff * diff)) >> 24);
                wt   = exp2_weight(e);
                num += wt * value_plane[idx];
                den += wt;
            end
        end
        res.filtered = (den != 0) ? SAMPLE_W'(num / den) : '0;
        res.last     = (pos + 1 == npix);
        out_pos      = (pos + 1 >= npix) ? 0 : pos + 1;
        pending.push_back(res);
    endfunction

    function void check_result(bif_out_t got);
        bif_out_t exp_res;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected pixel filtered=%h last=%b", $time,
                got.filtered, got.last);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (got.filtered !== exp_res.filtered)
        begin
            $display("%0t: filtered expected %h actual %h", $time,
                exp_res.filtered, got.filtered);
            errors++;
        end
        if (got.last !== exp_res.last)
        begin
            $display("%0t: last expected %b actual %b", $time, exp_res.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_bilateral_image_filter;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    bif_in_t              req;
    logic                 done;
    bif_out_t             result;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pixel_scoreboard      board;
    int                   idle_cycles;
    int                   items_sent;
    int                   w;
    int                   h;
    int                   npix;

    bilateral_image_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("bilateral_image_filter verification failed");
            $finish;
        end
    end

    // random gap, mostly short with a few long ones
    function automatic int gap_len();
        int n;
        case ($urandom_range(9))
            0, 1, 2, 3: n = 0;
            9:          n = $urandom_range(300, 20);
            default:    n = $urandom_range(3, 1);
        endcase
        return n;
    endfunction

    task automatic send_item(logic cmd, logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] g);
        bif_in_t item;
        int      n;
        item.command      = cmd;
        item.sample       = s;
        item.guide_sample = g;
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_input(item);
        items_sent++;
        // start stays high into the next transaction when there is no gap
        n = gap_len();
        if (n > 0)
        begin
            start <= 1'b0;
            req   <= bif_in_t'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // wait for all pixels to be checked and busy to fall, then idle before touching registers
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic setup(int w, int h, int r, int sp, int rg, int ug, int bm);
        drain();
        write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        write_reg(CFG_WINDOW_RADIUS, CFG_W'(r));
        write_reg(CFG_SPATIAL_COEFF, CFG_W'(sp));
        write_reg(CFG_RANGE_COEFF, CFG_W'(rg));
        write_reg(CFG_USE_GUIDE, CFG_W'(ug));
        write_reg(CFG_BORDER_MODE, CFG_W'(bm));
        cfg_write <= 1'b0;
    endtask

    // load a whole frame with random or flat content, then compute some of it
    task automatic run_frame(int computes, int flavor);
        int npix;
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] g;
        npix = board.frame_w() * board.frame_h();
        for (int i = 0; i < npix; i++)
        begin
            case (flavor)
                0:
                begin
                    s = SAMPLE_W'($urandom);
                    g = SAMPLE_W'($urandom);
                end
                1:
                begin
                    s = 16'hFFFF;
                    g = 16'h0000;
                end
                default:
                begin
                    s = SAMPLE_W'($urandom_range(2) * 16'h7FFF);
                    g = SAMPLE_W'($urandom);
                end
            endcase
            send_item(CMD_LOAD, s, g);
        end
        for (int i = 0; i < computes; i++)
            send_item(CMD_COMPUTE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    endtask

    initial
    begin
        board      = new();
        items_sent = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tiny frames, extreme registers, both border modes
        setup(1, 1, 0, 0, 0, 0, 0);
        run_frame(2, 1);
        setup(2, 2, 7, 0, 24'hFFFFFF, 1, 1);
        run_frame(4, 2);
        setup(3, 2, 7, 24'hFFFFFF, 0, 0, 0);
        run_frame(6, 0);
        setup(0, 127, 7, 5243, 461568, 1, 1);
        run_frame(3, 0);

        // random phases; mostly small frames, an occasional full-width one
        while (items_sent < 1950)
        begin
            if ($urandom_range(19) == 0)
            begin
                w = 64;
                h = $urandom_range(3, 1);
            end
            else
            begin
                w = $urandom_range(8, 1);
                h = $urandom_range(8, 1);
            end
            setup(w, h, $urandom_range(7), $urandom_range(2) == 0 ? $urandom : $urandom_range(70000),
                $urandom_range(1) ? $urandom : $urandom_range(600000),
                $urandom_range(1), $urandom_range(1));
            npix = w * h;
            // pixel rows may be partially unloaded when starting mid frame; reload all
            run_frame((npix > 40) ? $urandom_range(30, 10) : npix + $urandom_range(npix),
                $urandom_range(2));
            // extra loads and computes in random order within the loaded frame
            repeat ($urandom_range(20))
                send_item(1'($urandom_range(1)), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("bilateral_image_filter verification clean");
        else
            $display("bilateral_image_filter verification failed");
        $finish;
    end

endmodule
